// File: hdl/radix_number_to_ascii_defines.svh
// Assertion macros of the radix number to ASCII RTL.
// Included by radix_number_to_ascii, the module that carries assertions; depends on nothing else.
`ifndef RADIX_NUMBER_TO_ASCII_DEFINES_SVH
`define RADIX_NUMBER_TO_ASCII_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define RNA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rna assertion failed");
// Next-cycle implication, disabled while reset is held.
`define RNA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rna assertion failed");
`else
`define RNA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RNA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/rna_pkg.sv
// Shared constants, types and functions of the radix number to ASCII block.
// Used by rna_digits and radix_number_to_ascii; depends on nothing.
package rna_pkg;

    // Digit store geometry: 22 slots cover the longest (octal) 64-bit value.
    localparam int DIGIT_SLOTS = 22;
    localparam int DIG_W       = 4;
    localparam int STORE_W     = DIGIT_SLOTS * DIG_W;
    localparam int VALUE_W     = 64;
    localparam int POS_W       = 6;
    localparam int DEF_MAX_PAD = 48;

    // Shift-and-add-3 runs two value bits per cycle.
    localparam int DD_STEPS = VALUE_W / 2;
    localparam int DD_CNT_W = $clog2(DD_STEPS);

    // Radix modes.
    localparam logic [1:0] MODE_OCT   = 2'd0;
    localparam logic [1:0] MODE_DEC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;
    localparam logic [1:0] MODE_HEX0X = 2'd3;

    // Character constants.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] HEX_OFFSET = 8'h57;   // 'a' minus ten
    localparam logic [3:0] DIG_TEN    = 4'ha;

    typedef logic [STORE_W-1:0] t_store;

    // Commands from the sequencer to the digit unit.
    typedef struct packed {
        logic start;
        logic pop;
    } t_dig_cmd;

    // Status from the digit unit to the sequencer.
    typedef struct packed {
        logic             busy;
        logic [DIG_W-1:0] top;
    } t_dig_stat;

    // ASCII code of one digit, lowercase above nine.
    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        logic [7:0] d8;
        d8 = {4'd0, d};
        if (d < DIG_TEN) begin
            return CH_ZERO + d8;
        end
        return d8 + HEX_OFFSET;
    endfunction

    // One shift-and-add-3 step: correct every BCD digit, then shift a bit in.
    function automatic t_store dd_step(input t_store bcd, input logic b);
        t_store           adj;
        logic [DIG_W-1:0] d;
        for (int j = 0; j < DIGIT_SLOTS; j++) begin
            d = bcd[j*DIG_W +: DIG_W];
            adj[j*DIG_W +: DIG_W] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return {adj[STORE_W-2:0], b};
    endfunction

endpackage

// File: hdl/rna_digits.sv
// Digit unit: splits a 64-bit value into radix digits and holds them for output.
// Decimal goes through a shift-and-add-3 stage; depends on rna_pkg.
module rna_digits (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rna_pkg::t_dig_cmd           i_cmd,
    input  logic [rna_pkg::VALUE_W-1:0] i_value,
    input  logic [1:0]                  i_mode,
    output rna_pkg::t_dig_stat          o_stat
);

    logic                         r_busy;
    logic [rna_pkg::DD_CNT_W-1:0] r_cnt;
    logic [rna_pkg::VALUE_W-1:0]  r_bin;
    rna_pkg::t_store              r_bcd;
    rna_pkg::t_store              w_direct;
    logic [rna_pkg::VALUE_W+1:0]  w_ext;

    // Octal and hex digits are plain slices of the value.
    always_comb begin
        w_ext    = {2'b00, i_value};
        w_direct = '0;
        for (int j = 0; j < rna_pkg::DIGIT_SLOTS; j++) begin
            if (i_mode == rna_pkg::MODE_OCT) begin
                w_direct[j*rna_pkg::DIG_W +: rna_pkg::DIG_W] = {1'b0, w_ext[3*j +: 3]};
            end else if (j < rna_pkg::VALUE_W / rna_pkg::DIG_W) begin
                w_direct[j*rna_pkg::DIG_W +: rna_pkg::DIG_W] = w_ext[4*j +: 4];
            end
        end
    end

    // Control: the decimal conversion counts down its steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= (i_mode == rna_pkg::MODE_DEC);
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    // Datapath: load, two shift-and-add-3 steps per cycle, or pop the top digit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bin <= i_value;
            r_cnt <= rna_pkg::DD_CNT_W'(rna_pkg::DD_STEPS - 1);
            r_bcd <= (i_mode == rna_pkg::MODE_DEC) ? '0 : w_direct;
        end else if (r_busy) begin
            r_bin <= {r_bin[rna_pkg::VALUE_W-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            r_bcd <= rna_pkg::dd_step(rna_pkg::dd_step(r_bcd, r_bin[rna_pkg::VALUE_W-1]),
                                      r_bin[rna_pkg::VALUE_W-2]);
        end else if (i_cmd.pop) begin
            r_bcd <= {r_bcd[rna_pkg::STORE_W-rna_pkg::DIG_W-1:0], {rna_pkg::DIG_W{1'b0}}};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.top  = r_bcd[rna_pkg::STORE_W-1 -: rna_pkg::DIG_W];

endmodule

// File: hdl/radix_number_to_ascii.sv
// Channel  Dir  Beat contents
// s        in   tdata = value[63:0], mode[65:64], pad_width[71:66]
// m        out  tdata = ch[7:0]; tlast = last character of the number
//
// Each number goes through a setup step (octal, hex) or the decimal conversion in the
// shift-and-add-3 stage at two bits a cycle, then skips leading zero slots, then
// emits one character per cycle while m is not stalled.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A stall on m holds the character in the output register and the sequencer before its next load.
// s is ready only while no number is in progress.
// Top level of the radix number to ASCII block; depends on rna_pkg, rna_digits
// and radix_number_to_ascii_defines.svh.
`include "radix_number_to_ascii_defines.svh"
module radix_number_to_ascii #(
    parameter int MAX_PAD = rna_pkg::DEF_MAX_PAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,    // value[63:0], mode[65:64], pad_width[71:66]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,    // ch[7:0]
    output logic        o_m_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_PRE0 = 3'd2;
    localparam logic [2:0] S_PREX = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [rna_pkg::POS_W-1:0] MAX_PAD_V = rna_pkg::POS_W'(MAX_PAD);
    localparam logic [rna_pkg::POS_W-1:0] SLOTS_V   = rna_pkg::POS_W'(rna_pkg::DIGIT_SLOTS);

    logic [2:0]                r_state;
    logic [1:0]                r_mode;
    logic [rna_pkg::POS_W-1:0] r_pad;
    logic [rna_pkg::POS_W-1:0] r_pos;
    logic                      r_lead;
    logic                      r_ovalid;
    logic [7:0]                r_ch;
    logic                      r_last;

    logic                      w_accept;
    logic [1:0]                w_mode;
    logic [rna_pkg::POS_W-1:0] w_pad_in;
    logic [rna_pkg::POS_W-1:0] w_pad_sat;
    logic                      w_slot;
    logic                      w_high;
    logic                      w_skip;
    logic                      w_load;
    logic [7:0]                w_ch;
    logic                      w_last;
    rna_pkg::t_dig_cmd         w_cmd;
    rna_pkg::t_dig_stat        w_stat;

    // Input beat fields and pad saturation.
    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_mode    = i_s_tdata[65:64];
    assign w_pad_in  = i_s_tdata[71:66];
    assign w_pad_sat = (w_pad_in > MAX_PAD_V) ? MAX_PAD_V : w_pad_in;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_slot     = !r_ovalid || i_m_tready;

    // Character selection for the current step.
    always_comb begin
        w_high = (r_pos >= SLOTS_V);
        w_skip = 1'b0;
        w_load = 1'b0;
        w_ch   = rna_pkg::CH_ZERO;
        w_last = 1'b0;
        case (r_state)
            S_PRE0: begin
                w_load = w_slot;
            end
            S_PREX: begin
                w_load = w_slot;
                w_ch   = rna_pkg::CH_X;
            end
            S_EMIT: begin
                // Leading zero slots beyond the pad width are dropped, but never the last one.
                w_skip = r_lead && !w_high && (r_pos >= r_pad) && (w_stat.top == '0)
                         && (r_pos != '0);
                w_load = !w_skip && w_slot;
                w_ch   = w_high ? rna_pkg::CH_ZERO : rna_pkg::digit_char(w_stat.top);
                w_last = (r_pos == '0);
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    assign w_cmd.start = w_accept;
    assign w_cmd.pop   = (r_state == S_EMIT) && !w_high && (w_skip || w_load);

    rna_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (i_s_tdata[rna_pkg::VALUE_W-1:0]),
        .i_mode  (w_mode),
        .o_stat  (w_stat)
    );

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (!w_stat.busy) begin
                        r_state <= (r_mode == rna_pkg::MODE_HEX0X) ? S_PRE0 : S_EMIT;
                    end
                end
                S_PRE0: begin
                    if (w_load) begin
                        r_state <= S_PREX;
                    end
                end
                S_PREX: begin
                    if (w_load) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load && w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Per-number context: mode, pad and the position being printed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= w_mode;
            r_pad  <= w_pad_sat;
            r_pos  <= (w_pad_sat > SLOTS_V) ? w_pad_sat - 1'b1 : SLOTS_V - 1'b1;
            r_lead <= 1'b1;
        end else if (r_state == S_EMIT && (w_skip || w_load)) begin
            r_pos <= r_pos - 1'b1;
            if (w_load) begin
                r_lead <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ch   <= w_ch;
            r_last <= w_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_ch;
    assign o_m_tlast  = r_last;

    // No character leaves while the decimal conversion is still running.
    `RNA_ASSERT_IMPL(a_no_load_busy, i_clk, i_rst_n, w_stat.busy, !w_load)
    // An accepted number always starts with the conversion step.
    `RNA_ASSERT_NEXT(a_accept_conv, i_clk, i_rst_n, w_accept, r_state == S_CONV)
    // The final character ends the number and frees the input side.
    `RNA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_load && w_last, r_state == S_IDLE)
    // A skip never happens once the first digit has gone out.
    `RNA_ASSERT_IMPL(a_skip_lead, i_clk, i_rst_n, w_skip, r_lead && !w_high)

endmodule
